/* sv/bsc_pkg.sv */
// shared field widths, codes and configuration constants of the safety check
`default_nettype none

package bsc_pkg;

    // field widths of the request and result channels
    localparam int ACTION_W   = 2;
    localparam int PROC_IDX_W = 4;
    localparam int RES_IDX_W  = 3;
    localparam int VALUE_W    = 16;
    localparam int PID_W      = 4;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int NP_CFG_W   = 5;
    localparam int NR_CFG_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCESSES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RESOURCES = 1'b1;

    localparam logic [NP_CFG_W-1:0] NP_CFG_RESET = 5'd16;
    localparam logic [NR_CFG_W-1:0] NR_CFG_RESET = 4'd8;

    // request codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_AVAIL = 2'd0,
        ACT_LOAD_PROC  = 2'd1,
        ACT_CHECK      = 2'd2
    } action_t;

endpackage

`default_nettype wire

/* sv/bsc_in_if.sv */
// request channel: loads and safety check requests
`default_nettype none

interface bsc_in_if
    import bsc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [ACTION_W-1:0]   action;
    logic [PROC_IDX_W-1:0] process_index;
    logic [RES_IDX_W-1:0]  resource_index;
    logic [VALUE_W-1:0]    avail_value;
    logic [VALUE_W-1:0]    max_value;
    logic [VALUE_W-1:0]    alloc_value;

    modport source (
        output valid, action, process_index, resource_index,
               avail_value, max_value, alloc_value,
        input  ready
    );

    modport sink (
        input  valid, action, process_index, resource_index,
               avail_value, max_value, alloc_value,
        output ready
    );
endinterface

`default_nettype wire

/* sv/bsc_out_if.sv */
// result channel: safe sequence entries or the unsafe verdict
`default_nettype none

interface bsc_out_if
    import bsc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             is_safe;
    logic [PID_W-1:0] process_id;
    logic             last;

    modport source (
        output valid, is_safe, process_id, last,
        input  ready
    );

    modport sink (
        input  valid, is_safe, process_id, last,
        output ready
    );
endinterface

`default_nettype wire

/* sv/bsc_pair_mem.sv */
// store of maximum and allocation pairs with one write port and a registered read port
`default_nettype none

module bsc_pair_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write on load, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/bankers_safety_check_core.sv */
// top level of the deadlock-avoidance safety check
`default_nettype none

// Deadlock-avoidance safety check. Load requests (available amount, or a
// process's maximum and allocation for one resource) and unused request
// codes are taken while idle and give no result. A check request copies the
// available vector into the work vector and walks the unfinished processes
// in index order, pass after pass, until all are finished (safe) or a pass
// finishes nobody (unsafe). One compare/add unit and the maximum/allocation
// store set the pace: each process visit begins with a select step, every
// resource tested takes a store read, then a compare, a process that fits
// takes a further store read and add per resource to add its allocation
// into work, and each pass end takes one more select step. Results then go
// out one per cycle while the sink is ready: np results with the safe
// sequence, or a single result with is_safe clear. The block takes no
// request from the check request until its last result is taken.

module bankers_safety_check_core
    import bsc_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int VALUE_BITS    = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    bsc_in_if.sink                     item,
    bsc_out_if.source                  result
);

    localparam int PW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW  = $clog2(MAX_PROCESSES + 1);
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int RCW = $clog2(MAX_RESOURCES + 1);
    localparam int MEM_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int WB  = VALUE_BITS + $clog2(MAX_PROCESSES + 1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SELECT   = 7'b0000010,
        ST_READ     = 7'b0000100,
        ST_TEST     = 7'b0001000,
        ST_ADD_READ = 7'b0010000,
        ST_ADD      = 7'b0100000,
        ST_EMIT     = 7'b1000000
    } state_t;

    // control registers
    state_t                   state_reg, state_next;
    logic [CW-1:0]            p_reg, p_next;
    logic [RW-1:0]            r_reg, r_next;
    logic [PW-1:0]            k_reg, k_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     found_reg, found_next;
    logic                     safe_reg, safe_next;
    logic [MAX_PROCESSES-1:0] done_reg, done_next;
    logic [NP_CFG_W-1:0]      np_cfg_reg;
    logic [NR_CFG_W-1:0]      nr_cfg_reg;

    // payload stores
    logic [VALUE_BITS-1:0]    avail_reg [MAX_RESOURCES];
    logic [WB-1:0]            work_reg  [MAX_RESOURCES];
    logic [PW-1:0]            seq_reg   [MAX_PROCESSES];

    logic [CW-1:0]            np_eff;
    logic [RCW-1:0]           nr_eff;
    logic                     r_last;
    logic                     k_last;
    logic                     accept;
    logic                     avail_we;
    logic                     mem_we;
    logic                     work_load;
    logic                     work_add;
    logic                     seq_we;
    logic [AW-1:0]            mem_waddr;
    logic [AW-1:0]            mem_raddr;
    logic [2*VALUE_BITS-1:0]  mem_wdata;
    logic [2*VALUE_BITS-1:0]  mem_rdata;
    logic [VALUE_BITS-1:0]    max_d;
    logic [VALUE_BITS-1:0]    alloc_d;
    logic [VALUE_BITS-1:0]    need_d;
    logic                     exceed;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_cfg_reg <= NP_CFG_RESET;
            nr_cfg_reg <= NR_CFG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NUM_PROCESSES)
            begin
                np_cfg_reg <= cfg_data[NP_CFG_W-1:0];
            end
            else if (cfg_index == CFG_NUM_RESOURCES)
            begin
                nr_cfg_reg <= cfg_data[NR_CFG_W-1:0];
            end
        end
    end

    // clamp the counts in use to between one and the built sizes
    always_comb
    begin
        if (np_cfg_reg == '0)
            np_eff = CW'(1);
        else if (32'(np_cfg_reg) > MAX_PROCESSES)
            np_eff = CW'(MAX_PROCESSES);
        else
            np_eff = CW'(np_cfg_reg);

        if (nr_cfg_reg == '0)
            nr_eff = RCW'(1);
        else if (32'(nr_cfg_reg) > MAX_RESOURCES)
            nr_eff = RCW'(MAX_RESOURCES);
        else
            nr_eff = RCW'(nr_cfg_reg);
    end

    assign r_last = (RCW'(r_reg) == nr_eff - RCW'(1));
    assign k_last = (CW'(k_reg) == np_eff - CW'(1));

    // request decode while idle
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign avail_we   = accept && (item.action == ACT_LOAD_AVAIL)
                        && (32'(item.resource_index) < MAX_RESOURCES);
    assign mem_we     = accept && (item.action == ACT_LOAD_PROC)
                        && (32'(item.resource_index) < MAX_RESOURCES)
                        && (32'(item.process_index) < MAX_PROCESSES);
    assign work_load  = accept && (item.action == ACT_CHECK);

    assign mem_waddr = AW'(PW'(item.process_index)) * AW'(MAX_RESOURCES)
                       + AW'(RW'(item.resource_index));
    assign mem_wdata = {VALUE_BITS'(item.max_value), VALUE_BITS'(item.alloc_value)};
    assign mem_raddr = AW'(p_reg[PW-1:0]) * AW'(MAX_RESOURCES) + AW'(r_reg);

    bsc_pair_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (AW),
        .DATA_W (2 * VALUE_BITS)
    ) u_bsc_pair_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared compare unit: does the need (maximum minus allocation, zero if not positive) exceed work
    assign max_d   = mem_rdata[2*VALUE_BITS-1:VALUE_BITS];
    assign alloc_d = mem_rdata[VALUE_BITS-1:0];
    assign need_d  = max_d - alloc_d;
    assign exceed  = (max_d > alloc_d) && (WB'(need_d) > work_reg[r_reg]);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        count_next = count_reg;
        found_next = found_reg;
        safe_next  = safe_reg;
        done_next  = done_reg;
        work_add   = 1'b0;
        seq_we     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (work_load)
                begin
                    p_next     = '0;
                    count_next = '0;
                    found_next = 1'b0;
                    done_next  = '0;
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (p_reg == np_eff)
                begin
                    // end of a pass
                    if (!found_reg)
                    begin
                        safe_next  = 1'b0;
                        k_next     = '0;
                        state_next = ST_EMIT;
                    end
                    else if (count_reg == np_eff)
                    begin
                        safe_next  = 1'b1;
                        k_next     = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        p_next     = '0;
                        found_next = 1'b0;
                    end
                end
                else if (done_reg[p_reg[PW-1:0]])
                begin
                    p_next = p_reg + CW'(1);
                end
                else
                begin
                    r_next     = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (exceed)
                begin
                    p_next     = p_reg + CW'(1);
                    state_next = ST_SELECT;
                end
                else if (r_last)
                begin
                    r_next     = '0;
                    state_next = ST_ADD_READ;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_READ;
                end
            end
            ST_ADD_READ:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                work_add = 1'b1;
                if (r_last)
                begin
                    // process finishes: record it in the sequence
                    done_next[p_reg[PW-1:0]] = 1'b1;
                    seq_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    found_next = 1'b1;
                    p_next     = p_reg + CW'(1);
                    state_next = ST_SELECT;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_ADD_READ;
                end
            end
            ST_EMIT:
            begin
                if (result.ready)
                begin
                    if (!safe_reg || k_last)
                        state_next = ST_IDLE;
                    else
                        k_next = k_reg + PW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            p_reg     <= '0;
            r_reg     <= '0;
            k_reg     <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
            safe_reg  <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
            count_reg <= count_next;
            found_reg <= found_next;
            safe_reg  <= safe_next;
            done_reg  <= done_next;
        end
    end

    // available, work and sequence stores
    always_ff @(posedge clk)
    begin
        if (avail_we)
        begin
            avail_reg[RW'(item.resource_index)] <= VALUE_BITS'(item.avail_value);
        end
        if (work_load)
        begin
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                work_reg[i] <= WB'(avail_reg[i]);
            end
        end
        else if (work_add)
        begin
            work_reg[r_reg] <= work_reg[r_reg] + WB'(alloc_d);
        end
        if (seq_we)
        begin
            seq_reg[count_reg[PW-1:0]] <= p_reg[PW-1:0];
        end
    end

    // result channel
    assign result.valid      = (state_reg == ST_EMIT);
    assign result.is_safe    = safe_reg;
    assign result.process_id = safe_reg ? PID_W'(seq_reg[k_reg]) : '0;
    assign result.last       = !safe_reg || k_last;

endmodule

`default_nettype wire

/* sv/bsc_checker.sv */
// port-level checks of the safety check core and their binding
`default_nettype none

module bsc_checker
    import bsc_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_ready,
    input wire logic [ACTION_W-1:0] item_action,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire logic                is_safe,
    input wire logic [PID_W-1:0]    process_id,
    input wire logic                last
);

    // a stalled result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(is_safe) && $stable(process_id) && $stable(last))
    else $error("stalled result changed");

    // no request taken while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
    else $error("request side open while results pending");

    // unsafe verdict is a single flagged result with id zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !is_safe |-> last && (process_id == '0))
    else $error("malformed unsafe result");

    // after a load or unused request the request side is ready again in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_action != ACT_CHECK) |=> item_ready)
    else $error("load request did not complete in one cycle");

    // a check request closes the request side
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_action == ACT_CHECK) |=> !item_ready)
    else $error("check request did not start a check");

endmodule

bind bankers_safety_check_core bsc_checker u_bsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_action  (item.action),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .is_safe      (result.is_safe),
    .process_id   (result.process_id),
    .last         (result.last)
);

`default_nettype wire
